// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, skipped while rst is high.
`define ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/sfde_pkg.sv =====
// ----------------------------------------------------------------------------
// Short-form directory entry parser package
// Types and constants shared by the parser, its output queue and the top level.
// ----------------------------------------------------------------------------
package sfde_pkg;

   localparam logic [3:0] HDR_BYTES_NARROW = 4'd6;
   localparam logic [3:0] HDR_BYTES_WIDE   = 4'd10;
   localparam logic [7:0] TAG_BYTES        = 8'd2;
   localparam logic [7:0] INODE_BYTES_NARROW = 8'd4;
   localparam logic [7:0] INODE_BYTES_WIDE   = 8'd8;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENTRY_COUNT       = 2'd0,
      CSR_WIDE_INODES       = 2'd1,
      CSR_FILE_TYPE_PRESENT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_LEN    = 3'd1,
      PH_TAG    = 3'd2,
      PH_NAME   = 3'd3,
      PH_FTYPE  = 3'd4,
      PH_INODE  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NAME_BYTE   = 2'd0,
      KIND_ENTRY_DONE  = 2'd1,
      KIND_EMPTY_TABLE = 2'd2,
      KIND_TRUNCATED   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] entry_count;
      logic       wide_inodes;
      logic       file_type_present;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  name_char;
      logic [7:0]  name_pos;
      logic [63:0] inode_value;
      logic [7:0]  name_len;
      logic [7:0]  entry_number;
      logic        final_entry;
   } result_type;

   typedef struct packed {
      phase_type phase;
      logic      table_done;
   } status_type;

endpackage

// ===== hw/rtl/sfde_parser.sv =====
// ----------------------------------------------------------------------------
// Short-form directory entry parser step
// Holds the parse state and decodes one table byte per accepted item.
// ----------------------------------------------------------------------------
module sfde_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  sfde_pkg::cfg_type    cfg,
   output logic                 result_valid,
   output sfde_pkg::result_type result,
   output sfde_pkg::status_type status
);
   import sfde_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  header_left_ff, header_left_in;
   logic [7:0]  entries_left_ff, entries_left_in;
   logic [7:0]  field_counter_ff, field_counter_in;
   logic [63:0] inode_acc_ff, inode_acc_in;
   logic [7:0]  name_len_ff, name_len_in;
   logic [7:0]  entry_counter_ff, entry_counter_in;
   logic        table_done_ff, table_done_in;

   logic [3:0]  hdr_size;
   logic [7:0]  inode_size;
   logic [3:0]  header_sum;
   logic [7:0]  field_sum;

   assign hdr_size   = cfg.wide_inodes ? HDR_BYTES_WIDE : HDR_BYTES_NARROW;
   assign inode_size = cfg.wide_inodes ? INODE_BYTES_WIDE : INODE_BYTES_NARROW;
   assign header_sum = header_left_ff + 4'd1;
   assign field_sum  = field_counter_ff + 8'd1;

   always_comb begin
      phase_in         = phase_ff;
      header_left_in   = header_left_ff;
      entries_left_in  = entries_left_ff;
      field_counter_in = field_counter_ff;
      inode_acc_in     = inode_acc_ff;
      name_len_in      = name_len_ff;
      entry_counter_in = entry_counter_ff;
      table_done_in    = table_done_ff;
      result           = '0;
      result_valid     = 1'b0;

      if (!table_done_ff) begin
         unique case (phase_ff)
            PH_HEADER: begin
               header_left_in = header_sum;
               if (header_sum >= hdr_size) begin
                  header_left_in   = 4'd0;
                  entry_counter_in = 8'd0;
                  if (cfg.entry_count == 8'd0) begin
                     table_done_in = 1'b1;
                     result.kind   = KIND_EMPTY_TABLE;
                     result_valid  = 1'b1;
                  end else begin
                     entries_left_in = cfg.entry_count;
                     phase_in        = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               name_len_in      = data_byte;
               field_counter_in = 8'd0;
               phase_in         = PH_TAG;
            end
            PH_TAG: begin
               field_counter_in = field_sum;
               if (field_sum >= TAG_BYTES) begin
                  field_counter_in = 8'd0;
                  if (name_len_ff != 8'd0) begin
                     phase_in = PH_NAME;
                  end else begin
                     inode_acc_in = '0;
                     phase_in     = cfg.file_type_present ? PH_FTYPE : PH_INODE;
                  end
               end
            end
            PH_NAME: begin
               result.kind         = KIND_NAME_BYTE;
               result.name_char    = data_byte;
               result.name_pos     = field_counter_ff;
               result.name_len     = name_len_ff;
               result.entry_number = entry_counter_ff;
               result_valid        = 1'b1;
               field_counter_in    = field_sum;
               if (field_sum >= name_len_ff) begin
                  field_counter_in = 8'd0;
                  inode_acc_in     = '0;
                  phase_in         = cfg.file_type_present ? PH_FTYPE : PH_INODE;
               end
            end
            PH_FTYPE: begin
               field_counter_in = 8'd0;
               inode_acc_in     = '0;
               phase_in         = PH_INODE;
            end
            PH_INODE: begin
               inode_acc_in     = {inode_acc_ff[55:0], data_byte};
               field_counter_in = field_sum;
               if (field_sum >= inode_size) begin
                  result.kind         = KIND_ENTRY_DONE;
                  result.inode_value  = inode_acc_in;
                  result.name_len     = name_len_ff;
                  result.entry_number = entry_counter_ff;
                  result.final_entry  = (entries_left_ff == 8'd1);
                  result_valid        = 1'b1;
                  entries_left_in     = entries_left_ff - 8'd1;
                  entry_counter_in    = entry_counter_ff + 8'd1;
                  field_counter_in    = 8'd0;
                  if (entries_left_in == 8'd0) begin
                     table_done_in = 1'b1;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end

      if (last_byte) begin
         if (!table_done_in) begin
            result       = '0;
            result.kind  = KIND_TRUNCATED;
            result_valid = 1'b1;
         end
         phase_in         = PH_HEADER;
         header_left_in   = 4'd0;
         entries_left_in  = 8'd0;
         field_counter_in = 8'd0;
         inode_acc_in     = '0;
         name_len_in      = 8'd0;
         entry_counter_in = 8'd0;
         table_done_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_left_ff   <= 4'd0;
         entries_left_ff  <= 8'd0;
         field_counter_ff <= 8'd0;
         inode_acc_ff     <= '0;
         name_len_ff      <= 8'd0;
         entry_counter_ff <= 8'd0;
         table_done_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         header_left_ff   <= header_left_in;
         entries_left_ff  <= entries_left_in;
         field_counter_ff <= field_counter_in;
         inode_acc_ff     <= inode_acc_in;
         name_len_ff      <= name_len_in;
         entry_counter_ff <= entry_counter_in;
         table_done_ff    <= table_done_in;
      end
   end

   assign status.phase      = phase_ff;
   assign status.table_done = table_done_ff;

endmodule

// ===== hw/rtl/sfde_outq.sv =====
// ----------------------------------------------------------------------------
// Short-form directory entry parser output queue
// Result register with a skid stage so the input side keeps moving on a stall.
// ----------------------------------------------------------------------------
module sfde_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfde_pkg::result_type push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sfde_pkg::result_type out_data,
   output logic                 skid_busy
);
   import sfde_pkg::*;

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_data_ff, head_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       head_free;

   assign head_free = !head_valid_ff || out_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_data_in  = head_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            head_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (head_free) begin
            head_valid_in = 1'b1;
            head_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (out_ready) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_data_ff <= head_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_data_ff;
   assign skid_busy = skid_valid_ff;

endmodule

// ===== hw/rtl/shortform_directory_entry_parser_core.sv =====
// ----------------------------------------------------------------------------
// Short-form directory entry parser core
// Parses a short-form directory table one byte per item.
// ----------------------------------------------------------------------------
// The req channel carries one table byte per item together with a flag that
// marks the final byte of the table. The rsp channel carries at most one item
// per byte: a name byte, a completed entry with its inode number, an empty
// table notice or a truncation error.
// Each byte is decoded in the cycle it is accepted and its result is taken
// into the result register, or the skid register on a stall. While the skid
// register is empty the sustained rate is one byte per clock.
// A result register and a skid register sit behind the decoder. When the
// receiver stalls, bytes that give no item keep flowing and the item of one
// more byte is still taken into the skid register, after which req_ready
// drops until the receiver takes an item.
// The csr port sets the entry count, the inode width and whether entries
// carry a file-type byte. Write it only while the block is idle (not enforced).
// Reset clears the parse state, the configuration and both output registers.
// A byte with req_last_byte set returns the parser to the start of a table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shortform_directory_entry_parser_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [sfde_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sfde_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [7:0]                             req_data_byte,
   input  logic                                   req_last_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_kind,
   output logic [7:0]                             rsp_name_char,
   output logic [7:0]                             rsp_name_pos,
   output logic [63:0]                            rsp_inode_value,
   output logic [7:0]                             rsp_name_len,
   output logic [7:0]                             rsp_entry_number,
   output logic                                   rsp_final_entry
);
   import sfde_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic       result_valid;
   result_type result;
   result_type rsp_data;
   status_type status;
   logic       skid_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:       cfg_in.entry_count       = csr_wdata;
            CSR_WIDE_INODES:       cfg_in.wide_inodes       = csr_wdata[0];
            CSR_FILE_TYPE_PRESENT: cfg_in.file_type_present = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = req_valid && req_ready;

   sfde_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .last_byte    (req_last_byte),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result),
      .status       (status)
   );

   sfde_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && result_valid),
      .push_data (result),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data),
      .skid_busy (skid_busy)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_name_char    = rsp_data.name_char;
   assign rsp_name_pos     = rsp_data.name_pos;
   assign rsp_inode_value  = rsp_data.inode_value;
   assign rsp_name_len     = rsp_data.name_len;
   assign rsp_entry_number = rsp_data.entry_number;
   assign rsp_final_entry  = rsp_data.final_entry;

   `ASSERT_SYNC(a_skid_behind_head, clock, reset, skid_busy |-> rsp_valid)
   `ASSERT_SYNC(a_last_restarts, clock, reset,
      (accept && req_last_byte) |=> (status.phase == PH_HEADER && !status.table_done))
   `ASSERT_SYNC(a_done_needs_item, clock, reset, $rose(status.table_done) |-> $past(accept))

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Short-form directory entry parser testbench
// Streams directory tables into the parser byte by byte. The tables are mostly
// well formed with random content, and some are truncated, left open across a
// configuration change or pure noise. A scoreboard predicts every result item
// and checks it field by field, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import sfde_pkg::*;

   class dir_entry_scoreboard;
      cfg_type    regs;
      phase_type  step;
      logic [3:0] hdr_seen;
      logic [7:0] remaining_entries;
      logic [7:0] byte_pos;
      logic [63:0] inode_acc;
      logic [7:0] cur_name_len;
      logic [7:0] entry_idx;
      bit         table_closed;
      result_type queued_results[$];
      int         mismatch_count;

      function new();
         regs = '0;
         mismatch_count = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         step = PH_HEADER;
         hdr_seen = '0;
         remaining_entries = '0;
         byte_pos = '0;
         inode_acc = '0;
         cur_name_len = '0;
         entry_idx = '0;
         table_closed = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] value);
         case (idx)
            CSR_ENTRY_COUNT:       regs.entry_count = value;
            CSR_WIDE_INODES:       regs.wide_inodes = value[0];
            CSR_FILE_TYPE_PRESENT: regs.file_type_present = value[0];
            default: ;
         endcase
      endfunction

      function void start_after_name();
         byte_pos = '0;
         inode_acc = '0;
         step = regs.file_type_present ? PH_FTYPE : PH_INODE;
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         result_type r;
         bit         emit;
         logic [3:0] hdr_size;
         logic [7:0] ino_size;
         r = '0;
         emit = 1'b0;
         if (!table_closed) begin
            case (step)
               PH_HEADER: begin
                  hdr_size = regs.wide_inodes ? HDR_BYTES_WIDE : HDR_BYTES_NARROW;
                  hdr_seen = hdr_seen + 4'd1;
                  if (hdr_seen >= hdr_size) begin
                     hdr_seen = '0;
                     entry_idx = '0;
                     if (regs.entry_count == 8'd0) begin
                        table_closed = 1'b1;
                        r.kind = KIND_EMPTY_TABLE;
                        emit = 1'b1;
                     end else begin
                        remaining_entries = regs.entry_count;
                        step = PH_LEN;
                     end
                  end
               end
               PH_LEN: begin
                  cur_name_len = b;
                  byte_pos = '0;
                  step = PH_TAG;
               end
               PH_TAG: begin
                  byte_pos = byte_pos + 8'd1;
                  if (byte_pos >= TAG_BYTES) begin
                     byte_pos = '0;
                     if (cur_name_len != 8'd0) step = PH_NAME;
                     else start_after_name();
                  end
               end
               PH_NAME: begin
                  r.kind = KIND_NAME_BYTE;
                  r.name_char = b;
                  r.name_pos = byte_pos;
                  r.name_len = cur_name_len;
                  r.entry_number = entry_idx;
                  emit = 1'b1;
                  byte_pos = byte_pos + 8'd1;
                  if (byte_pos >= cur_name_len) start_after_name();
               end
               PH_FTYPE: begin
                  byte_pos = '0;
                  inode_acc = '0;
                  step = PH_INODE;
               end
               default: begin
                  ino_size = regs.wide_inodes ? INODE_BYTES_WIDE : INODE_BYTES_NARROW;
                  inode_acc = {inode_acc[55:0], b};
                  byte_pos = byte_pos + 8'd1;
                  if (byte_pos >= ino_size) begin
                     r.kind = KIND_ENTRY_DONE;
                     r.inode_value = inode_acc;
                     r.name_len = cur_name_len;
                     r.entry_number = entry_idx;
                     r.final_entry = (remaining_entries == 8'd1);
                     emit = 1'b1;
                     remaining_entries = remaining_entries - 8'd1;
                     entry_idx = entry_idx + 8'd1;
                     byte_pos = '0;
                     if (remaining_entries == 8'd0) table_closed = 1'b1;
                     else step = PH_LEN;
                  end
               end
            endcase
         end
         if (last) begin
            if (!table_closed) begin
               r = '0;
               r.kind = KIND_TRUNCATED;
               emit = 1'b1;
            end
            clear_parse();
         end
         if (emit) queued_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (queued_results.size() == 0) begin
            $error("kind: expected no item, got 0x%0h", got.kind);
            mismatch_count++;
            return;
         end
         want = queued_results.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("name_char", want.name_char, got.name_char);
         compare_field("name_pos", want.name_pos, got.name_pos);
         compare_field("inode_value", want.inode_value, got.inode_value);
         compare_field("name_len", want.name_len, got.name_len);
         compare_field("entry_number", want.entry_number, got.entry_number);
         compare_field("final_entry", want.final_entry, got.final_entry);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = '0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_name_char;
   logic [7:0] rsp_name_pos;
   logic [63:0] rsp_inode_value;
   logic [7:0] rsp_name_len;
   logic [7:0] rsp_entry_number;
   logic rsp_final_entry;

   dir_entry_scoreboard sb = new();
   bit steady_flow = 1'b0;
   int items_sent = 0;

   shortform_directory_entry_parser_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_name_char    (rsp_name_char),
      .rsp_name_pos     (rsp_name_pos),
      .rsp_inode_value  (rsp_inode_value),
      .rsp_name_len     (rsp_name_len),
      .rsp_entry_number (rsp_entry_number),
      .rsp_final_entry  (rsp_final_entry)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic send_byte(logic [7:0] data, logic last);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      sb.take_byte(data, last);
      @(negedge clock);
   endtask

   task automatic send_stream(logic [7:0] stream[$], int count, bit last_at_end);
      for (int i = 0; i < count; i++) send_byte(stream[i], last_at_end && (i == count - 1));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.queued_results.size() != 0) @(negedge clock);
      // Covers bytes still in the decoder that give no item.
      repeat (6) @(negedge clock);
   endtask

   task automatic write_regs(logic [7:0] entries, logic wide, logic ftype);
      csr_index_type idx [3];
      logic [7:0]    value [3];
      idx = '{CSR_ENTRY_COUNT, CSR_WIDE_INODES, CSR_FILE_TYPE_PRESENT};
      value = '{entries, {7'd0, wide}, {7'd0, ftype}};
      for (int i = 0; i < 3; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= value[i];
         sb.write_reg(idx[i], value[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_table(int fixed_len, bit whole_only);
      logic [7:0] stream[$];
      int hsize;
      int isize;
      int nl;
      int body_len;
      int style;
      int cut;
      hsize = sb.regs.wide_inodes ? 10 : 6;
      isize = sb.regs.wide_inodes ? 8 : 4;
      repeat (hsize) stream.push_back(8'($urandom));
      repeat (sb.regs.entry_count) begin
         nl = (fixed_len >= 0) ? fixed_len : $urandom_range(0, 6);
         stream.push_back(8'(nl));
         repeat (2 + nl) stream.push_back(8'($urandom));
         if (sb.regs.file_type_present) stream.push_back(8'($urandom));
         repeat (isize) stream.push_back(8'($urandom));
      end
      body_len = stream.size();
      repeat ($urandom_range(0, 2)) stream.push_back(8'($urandom));
      style = whole_only ? 0 : $urandom_range(0, 9);
      if (style < 6) begin
         send_stream(stream, stream.size(), 1'b1);
         items_sent += body_len;
      end else if (style < 9) begin
         // Truncated tables end with the final flag, open ones end without it.
         cut = (style < 8) ? $urandom_range(0, body_len - 2) : $urandom_range(0, body_len - 1);
         send_stream(stream, cut + 1, style < 8);
         items_sent += cut + 1;
      end else begin
         stream.delete();
         repeat ($urandom_range(1, 12)) stream.push_back(8'($urandom));
         send_stream(stream, stream.size(), 1'($urandom_range(0, 1)));
         items_sent += stream.size();
      end
   endtask

   initial begin
      result_type got;
      int stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.kind = kind_type'(rsp_kind);
         got.name_char = rsp_name_char;
         got.name_pos = rsp_name_pos;
         got.inode_value = rsp_inode_value;
         got.name_len = rsp_name_len;
         got.entry_number = rsp_entry_number;
         got.final_entry = rsp_final_entry;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      logic [7:0] stream[$];
      int phase_no;
      logic [7:0] entries;
      int fixed_len;
      bit whole_only;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_regs(8'd0, 1'b0, 1'b0);
      stream = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
      send_stream(stream, stream.size(), 1'b1);
      stream = {8'hFF, 8'h00, 8'hFF};
      send_stream(stream, stream.size(), 1'b1);
      wait_idle();
      write_regs(8'd1, 1'b0, 1'b1);
      stream = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF,
                8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h80};
      send_stream(stream, stream.size(), 1'b1);
      items_sent += 25;

      phase_no = 0;
      while (items_sent < 625) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       entries = 8'd0;
            1:       entries = 8'd1;
            default: entries = 8'($urandom_range(1, 4));
         endcase
         fixed_len = -1;
         whole_only = 1'b0;
         if (phase_no == 4) begin
            // Many entries, with empty names to keep the table short.
            write_regs(8'd16, 1'b0, 1'b0);
            fixed_len = 0;
            whole_only = 1'b1;
         end else if (phase_no == 7) begin
            write_regs(8'd1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            fixed_len = 255;
            whole_only = 1'b1;
         end else begin
            write_regs(entries, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         steady_flow = ($urandom_range(0, 3) == 0);
         repeat (whole_only ? 1 : $urandom_range(1, 2)) send_table(fixed_len, whole_only);
         phase_no++;
      end

      wait_idle();
      if (sb.mismatch_count == 0 && sb.queued_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
